[src/smu_pkg.sv]
// ============================================================================
// smu_pkg
// Shared types and constants of the sorted ID list union merge.
// ============================================================================
package smu_pkg;

    // Default sizing of the merge
    localparam int MAX_LISTS_DEF  = 8;
    localparam int ID_BITS_DEF    = 32;
    localparam int SCORE_BITS_DEF = 16;

    // Fixed field widths
    localparam int LIST_INDEX_W = 3;
    localparam int KIND_W       = 2;
    localparam int MASK_OUT_W   = 8;
    localparam int CFG_LISTS_W  = 4;

    // APB register port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_ACTIVE_LISTS = 1'b0;   // word address of active_lists
    localparam logic [CFG_LISTS_W-1:0] ACTIVE_LISTS_RST = 4'd2;

    // Input function codes
    localparam logic FUNC_START   = 1'b0;
    localparam logic FUNC_DELIVER = 1'b1;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_WAIT     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RECORD   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FINISHED = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic take_item;   // apply the accepted transaction to the heads
        logic evaluate;    // decide: answer now or scan the heads
        logic scan_step;   // compare one stored head
        logic load_out;    // move the finished result to the output register
    } ctl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic need_scan;   // unfinished delivery with every live list holding a head
        logic scan_last;   // current scan slot is the last list
    } dp_sts_t;

endpackage

[src/smu_in_if.sv]
// ============================================================================
// smu_in_if
// Input channel: head deliveries, end marks and union starts.
// ============================================================================
interface smu_in_if #(
    parameter int ID_BITS    = smu_pkg::ID_BITS_DEF,
    parameter int SCORE_BITS = smu_pkg::SCORE_BITS_DEF
);
    logic                            valid;
    logic                            ready;
    logic                            func;
    logic [smu_pkg::LIST_INDEX_W-1:0] list_index;
    logic [ID_BITS-1:0]              record_id;
    logic [SCORE_BITS-1:0]           score;
    logic                            list_end;

    modport source (
        output valid, func, list_index, record_id, score, list_end,
        input  ready
    );

    modport sink (
        input  valid, func, list_index, record_id, score, list_end,
        output ready
    );
endinterface

[src/smu_out_if.sv]
// ============================================================================
// smu_out_if
// Output channel: one status or merged record per input transaction.
// ============================================================================
interface smu_out_if #(
    parameter int ID_BITS    = smu_pkg::ID_BITS_DEF,
    parameter int SCORE_BITS = smu_pkg::SCORE_BITS_DEF
);
    logic                           valid;
    logic                           ready;
    logic [smu_pkg::KIND_W-1:0]     kind;
    logic [ID_BITS-1:0]             out_id;
    logic [SCORE_BITS-1:0]          best_score;
    logic [smu_pkg::MASK_OUT_W-1:0] match_mask;
    logic [smu_pkg::MASK_OUT_W-1:0] refill_mask;

    modport source (
        output valid, kind, out_id, best_score, match_mask, refill_mask,
        input  ready
    );

    modport sink (
        input  valid, kind, out_id, best_score, match_mask, refill_mask,
        output ready
    );
endinterface

[src/smu_cfg.sv]
// ============================================================================
// smu_cfg
// APB register file holding the number of lists in the union.
// ============================================================================
module smu_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [smu_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [smu_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [smu_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,
    output logic [smu_pkg::CFG_LISTS_W-1:0]    active_lists
);
    localparam int DATA_W = smu_pkg::APB_DATA_W;
    localparam int LIST_W = smu_pkg::CFG_LISTS_W;

    logic              word_addr;
    logic              wr_hit;
    logic [LIST_W-1:0] active_lists_reg;
    logic [LIST_W-1:0] active_lists_next;

    // Register decode on the word address
    assign word_addr = paddr[2];
    assign wr_hit    = psel && penable && pwrite
                       && (word_addr == smu_pkg::REG_ACTIVE_LISTS);
    assign pready    = 1'b1;

    always_comb
    begin
        active_lists_next = active_lists_reg;
        if (wr_hit)
        begin
            active_lists_next = pwdata[LIST_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_lists_reg <= smu_pkg::ACTIVE_LISTS_RST;
        end
        else
        begin
            active_lists_reg <= active_lists_next;
        end
    end

    // Read back
    assign prdata = (word_addr == smu_pkg::REG_ACTIVE_LISTS)
                    ? DATA_W'(active_lists_reg) : '0;

    assign active_lists = active_lists_reg;
endmodule

[src/smu_ctrl.sv]
// ============================================================================
// smu_ctrl
// Sequencer: accept, evaluate, head scan and result hand-off.
// ============================================================================
module smu_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output smu_pkg::ctl_cmd_t cmd,
    input  smu_pkg::dp_sts_t  sts
);
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EVAL   = 2'd1;
    localparam logic [1:0] S_SCAN   = 2'd2;
    localparam logic [1:0] S_RESULT = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    // Output register can take a new result when empty or draining
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        in_ready       = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take_item = 1'b1;
                    state_next    = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.evaluate = 1'b1;
                state_next   = sts.need_scan ? S_SCAN : S_RESULT;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
endmodule

[src/smu_dp.sv]
// ============================================================================
// smu_dp
// Head store, list status, serial minimum scan and result registers.
// ============================================================================
module smu_dp #(
    parameter int MAX_LISTS  = smu_pkg::MAX_LISTS_DEF,
    parameter int ID_BITS    = smu_pkg::ID_BITS_DEF,
    parameter int SCORE_BITS = smu_pkg::SCORE_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  smu_pkg::ctl_cmd_t                  cmd,
    output smu_pkg::dp_sts_t                   sts,
    input  logic [smu_pkg::CFG_LISTS_W-1:0]    active_lists,
    input  logic                               in_func,
    input  logic [smu_pkg::LIST_INDEX_W-1:0]   in_list_index,
    input  logic [ID_BITS-1:0]                 in_record_id,
    input  logic [SCORE_BITS-1:0]              in_score,
    input  logic                               in_list_end,
    output logic [smu_pkg::KIND_W-1:0]         out_kind,
    output logic [ID_BITS-1:0]                 out_id,
    output logic [SCORE_BITS-1:0]              out_best_score,
    output logic [smu_pkg::MASK_OUT_W-1:0]     out_match_mask,
    output logic [smu_pkg::MASK_OUT_W-1:0]     out_refill_mask
);
    localparam int IDX_W  = (MAX_LISTS > 1) ? $clog2(MAX_LISTS) : 1;
    localparam int CNT_W  = $clog2(MAX_LISTS + 1);
    localparam int KIND_W = smu_pkg::KIND_W;
    localparam int OMSK_W = smu_pkg::MASK_OUT_W;
    localparam logic [MAX_LISTS-1:0] ONE_BIT = MAX_LISTS'(1);

    // Head store (written on delivery, read only while present)
    logic [ID_BITS-1:0]    head_ids_reg    [MAX_LISTS];
    logic [SCORE_BITS-1:0] head_scores_reg [MAX_LISTS];
    logic                  head_we;
    logic [IDX_W-1:0]      head_wr_idx;

    // List status
    logic [MAX_LISTS-1:0] present_reg, present_next;
    logic [MAX_LISTS-1:0] done_reg, done_next;
    logic [ID_BITS-1:0]   last_reg, last_next;
    logic                 emitted_reg, emitted_next;
    logic                 finished_reg, finished_next;
    logic                 func_reg, func_next;

    // Scan state
    logic [CNT_W-1:0]      scan_cnt_reg, scan_cnt_next;
    logic                  found_reg, found_next;
    logic [ID_BITS-1:0]    best_id_reg, best_id_next;
    logic [SCORE_BITS-1:0] best_sc_reg, best_sc_next;
    logic [MAX_LISTS-1:0]  mmask_reg, mmask_next;

    // Pending result
    logic [KIND_W-1:0]     res_kind_reg, res_kind_next;
    logic [ID_BITS-1:0]    res_id_reg, res_id_next;
    logic [SCORE_BITS-1:0] res_sc_reg, res_sc_next;
    logic [MAX_LISTS-1:0]  res_mmask_reg, res_mmask_next;
    logic [MAX_LISTS-1:0]  res_rmask_reg, res_rmask_next;

    // Output register
    logic [KIND_W-1:0]     o_kind_reg, o_kind_next;
    logic [ID_BITS-1:0]    o_id_reg, o_id_next;
    logic [SCORE_BITS-1:0] o_sc_reg, o_sc_next;
    logic [OMSK_W-1:0]     o_mmask_reg, o_mmask_next;
    logic [OMSK_W-1:0]     o_rmask_reg, o_rmask_next;

    // Combinational helpers
    logic [CNT_W-1:0]      n_lists;
    logic [MAX_LISTS-1:0]  all_mask;
    logic [MAX_LISTS-1:0]  live;
    logic [MAX_LISTS-1:0]  sel_mask;
    logic                  in_range;
    logic [IDX_W-1:0]      scan_idx;
    logic [ID_BITS-1:0]    cur_id;
    logic [SCORE_BITS-1:0] cur_sc;
    logic [MAX_LISTS-1:0]  cur_bit;
    logic                  step_found;
    logic [ID_BITS-1:0]    step_id;
    logic [SCORE_BITS-1:0] step_sc;
    logic [MAX_LISTS-1:0]  step_mm;
    logic [MAX_LISTS-1:0]  present_after;

    // Clamp the list count to 1..MAX_LISTS and build the member masks
    always_comb
    begin
        if (active_lists == '0)
        begin
            n_lists = CNT_W'(1);
        end
        else if (int'(active_lists) > MAX_LISTS)
        begin
            n_lists = CNT_W'(MAX_LISTS);
        end
        else
        begin
            n_lists = CNT_W'(active_lists);
        end

        in_range = int'(in_list_index) < int'(n_lists);
        for (int i = 0; i < MAX_LISTS; i++)
        begin
            all_mask[i] = i < int'(n_lists);
            sel_mask[i] = in_range && (i == int'(in_list_index));
        end
        live = all_mask & ~done_reg;
    end

    assign sts.need_scan = (func_reg == smu_pkg::FUNC_DELIVER) && !finished_reg
                           && (live != '0) && ((present_reg & live) == live);
    assign sts.scan_last = scan_cnt_reg == (n_lists - CNT_W'(1));

    // One head compared per cycle against the running minimum
    always_comb
    begin
        scan_idx   = scan_cnt_reg[IDX_W-1:0];
        cur_id     = head_ids_reg[scan_idx];
        cur_sc     = head_scores_reg[scan_idx];
        cur_bit    = ONE_BIT << scan_idx;
        step_found = found_reg;
        step_id    = best_id_reg;
        step_sc    = best_sc_reg;
        step_mm    = mmask_reg;
        if (live[scan_idx])
        begin
            if (!found_reg || (cur_id < best_id_reg))
            begin
                step_found = 1'b1;
                step_id    = cur_id;
                step_sc    = cur_sc;
                step_mm    = cur_bit;
            end
            else if (cur_id == best_id_reg)
            begin
                if (cur_sc > best_sc_reg)
                begin
                    step_sc = cur_sc;
                end
                step_mm = mmask_reg | cur_bit;
            end
        end
        present_after = present_reg & ~step_mm;
    end

    // Next-state logic for status, scan and result registers
    always_comb
    begin
        present_next   = present_reg;
        done_next      = done_reg;
        last_next      = last_reg;
        emitted_next   = emitted_reg;
        finished_next  = finished_reg;
        func_next      = func_reg;
        scan_cnt_next  = scan_cnt_reg;
        found_next     = found_reg;
        best_id_next   = best_id_reg;
        best_sc_next   = best_sc_reg;
        mmask_next     = mmask_reg;
        res_kind_next  = res_kind_reg;
        res_id_next    = res_id_reg;
        res_sc_next    = res_sc_reg;
        res_mmask_next = res_mmask_reg;
        res_rmask_next = res_rmask_reg;
        o_kind_next    = o_kind_reg;
        o_id_next      = o_id_reg;
        o_sc_next      = o_sc_reg;
        o_mmask_next   = o_mmask_reg;
        o_rmask_next   = o_rmask_reg;
        head_we        = 1'b0;
        head_wr_idx    = IDX_W'(in_list_index);

        // Apply the accepted transaction
        if (cmd.take_item)
        begin
            func_next = in_func;
            if (in_func == smu_pkg::FUNC_START)
            begin
                present_next  = '0;
                done_next     = '0;
                last_next     = '0;
                emitted_next  = 1'b0;
                finished_next = 1'b0;
            end
            else if (!finished_reg && in_range)
            begin
                if (in_list_end)
                begin
                    done_next    = done_reg | sel_mask;
                    present_next = present_reg & ~sel_mask;
                end
                else if ((done_reg & sel_mask) == '0)
                begin
                    // repeat IDs at or behind the merge front are dropped
                    if (emitted_reg && (in_record_id <= last_reg))
                    begin
                        present_next = present_reg & ~sel_mask;
                    end
                    else
                    begin
                        head_we      = 1'b1;
                        present_next = present_reg | sel_mask;
                    end
                end
            end
        end

        // Decide the answer or start the scan
        if (cmd.evaluate)
        begin
            res_id_next    = '0;
            res_sc_next    = '0;
            res_mmask_next = '0;
            res_rmask_next = '0;
            res_kind_next  = smu_pkg::KIND_WAIT;
            scan_cnt_next  = '0;
            found_next     = 1'b0;
            mmask_next     = '0;
            priority if (func_reg == smu_pkg::FUNC_START)
            begin
                res_rmask_next = all_mask;
            end
            else if (finished_reg)
            begin
                res_kind_next = smu_pkg::KIND_FINISHED;
            end
            else if (live == '0)
            begin
                finished_next = 1'b1;
                res_kind_next = smu_pkg::KIND_FINISHED;
            end
            else
            begin
                res_rmask_next = live & ~present_reg;
            end
        end

        // Scan one list; commit the merged record on the last one
        if (cmd.scan_step)
        begin
            found_next    = step_found;
            best_id_next  = step_id;
            best_sc_next  = step_sc;
            mmask_next    = step_mm;
            scan_cnt_next = scan_cnt_reg + CNT_W'(1);
            if (sts.scan_last)
            begin
                present_next   = present_after;
                last_next      = step_id;
                emitted_next   = 1'b1;
                res_kind_next  = smu_pkg::KIND_RECORD;
                res_id_next    = step_id;
                res_sc_next    = step_sc;
                res_mmask_next = step_mm;
                res_rmask_next = live & ~present_after;
            end
        end

        // Hand the result to the output register
        if (cmd.load_out)
        begin
            o_kind_next  = res_kind_reg;
            o_id_next    = res_id_reg;
            o_sc_next    = res_sc_reg;
            o_mmask_next = OMSK_W'(res_mmask_reg);
            o_rmask_next = OMSK_W'(res_rmask_reg);
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg  <= '0;
            done_reg     <= '0;
            last_reg     <= '0;
            emitted_reg  <= 1'b0;
            finished_reg <= 1'b0;
            func_reg     <= smu_pkg::FUNC_START;
        end
        else
        begin
            present_reg  <= present_next;
            done_reg     <= done_next;
            last_reg     <= last_next;
            emitted_reg  <= emitted_next;
            finished_reg <= finished_next;
            func_reg     <= func_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        scan_cnt_reg  <= scan_cnt_next;
        found_reg     <= found_next;
        best_id_reg   <= best_id_next;
        best_sc_reg   <= best_sc_next;
        mmask_reg     <= mmask_next;
        res_kind_reg  <= res_kind_next;
        res_id_reg    <= res_id_next;
        res_sc_reg    <= res_sc_next;
        res_mmask_reg <= res_mmask_next;
        res_rmask_reg <= res_rmask_next;
        o_kind_reg    <= o_kind_next;
        o_id_reg      <= o_id_next;
        o_sc_reg      <= o_sc_next;
        o_mmask_reg   <= o_mmask_next;
        o_rmask_reg   <= o_rmask_next;
    end

    // Head store write port
    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            head_ids_reg[head_wr_idx]    <= in_record_id;
            head_scores_reg[head_wr_idx] <= in_score;
        end
    end

    assign out_kind        = o_kind_reg;
    assign out_id          = o_id_reg;
    assign out_best_score  = o_sc_reg;
    assign out_match_mask  = o_mmask_reg;
    assign out_refill_mask = o_rmask_reg;
endmodule

[src/sorted_id_list_union_merge.sv]
// ============================================================================
// sorted_id_list_union_merge
// K-way union merge of ascending record ID lists with duplicate removal.
// ============================================================================
//  channel   dir   handshake        payload
//  in_ch     in    valid / ready    func, list_index, record_id, score, list_end
//  out_ch    out   valid / ready    kind, out_id, best_score, match_mask,
//                                   refill_mask
//  apb       in    psel / penable   active_lists at byte address 0
//
//  One transaction in gives one transaction out. A transaction that emits a
//  record passes through accept, evaluate, a minimum scan over the n lists in
//  the union (at most MAX_LISTS) and result hand-off: the minimum scan reads
//  one stored head per cycle. All other transactions skip the scan.
//  The output register holds a finished result while the next transaction is
//  accepted; a stalled output only holds the block once a second result is
//  ready. Reset is asynchronous, active low, and needs no clearing pass.
// ============================================================================
module sorted_id_list_union_merge #(
    parameter int MAX_LISTS  = smu_pkg::MAX_LISTS_DEF,
    parameter int ID_BITS    = smu_pkg::ID_BITS_DEF,
    parameter int SCORE_BITS = smu_pkg::SCORE_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [smu_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [smu_pkg::APB_DATA_W-1:0] pwdata,
    output logic [smu_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    smu_in_if.sink                         in_ch,
    smu_out_if.source                      out_ch
);
    logic [smu_pkg::CFG_LISTS_W-1:0] active_lists;
    smu_pkg::ctl_cmd_t               cmd;
    smu_pkg::dp_sts_t                sts;
    logic                            in_ready;
    logic                            out_valid;

    // Register port
    smu_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .active_lists (active_lists)
    );

    // Sequencer
    smu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // Heads, scan and result registers
    smu_dp #(
        .MAX_LISTS  (MAX_LISTS),
        .ID_BITS    (ID_BITS),
        .SCORE_BITS (SCORE_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .active_lists    (active_lists),
        .in_func         (in_ch.func),
        .in_list_index   (in_ch.list_index),
        .in_record_id    (in_ch.record_id),
        .in_score        (in_ch.score),
        .in_list_end     (in_ch.list_end),
        .out_kind        (out_ch.kind),
        .out_id          (out_ch.out_id),
        .out_best_score  (out_ch.best_score),
        .out_match_mask  (out_ch.match_mask),
        .out_refill_mask (out_ch.refill_mask)
    );

    assign in_ch.ready  = in_ready;
    assign out_ch.valid = out_valid;
endmodule

[tb/sorted_id_list_union_merge_chk.sv]
// ============================================================================
// sorted_id_list_union_merge_chk
// Watches the register port and both channels of the union merge, keeps its
// own copy of the heads and flags, and compares every output transaction
// field by field with the oldest predicted result.
// ============================================================================
module sorted_id_list_union_merge_chk (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [smu_pkg::APB_ADDR_W-1:0]        paddr,
    input  logic [smu_pkg::APB_DATA_W-1:0]        pwdata,
    input  logic                                  pready,
    smu_in_if                                     in_ch,
    smu_out_if                                    out_ch,
    output int                                    fail_count,
    output int                                    pending,
    output int                                    taken,
    output int                                    records,
    output int                                    finishes,
    output int                                    cfg_writes,
    output logic [smu_pkg::MASK_OUT_W-1:0]        refill_need,
    output logic                                  union_done
);

    localparam int NL = smu_pkg::MAX_LISTS_DEF;
    localparam logic [smu_pkg::APB_ADDR_W-1:0] LISTS_ADDR =
        {smu_pkg::REG_ACTIVE_LISTS, 2'b00};

    typedef struct packed {
        logic [smu_pkg::KIND_W-1:0]         kind;
        logic [smu_pkg::ID_BITS_DEF-1:0]    id;
        logic [smu_pkg::SCORE_BITS_DEF-1:0] score;
        logic [smu_pkg::MASK_OUT_W-1:0]     mmask;
        logic [smu_pkg::MASK_OUT_W-1:0]     rmask;
    } merge_res_t;

    // Mirror of the merge state
    logic [smu_pkg::CFG_LISTS_W-1:0]    cfg_lists;
    logic [smu_pkg::ID_BITS_DEF-1:0]    hd_id [NL];
    logic [smu_pkg::SCORE_BITS_DEF-1:0] hd_sc [NL];
    logic [smu_pkg::MASK_OUT_W-1:0]     hd_valid;
    logic [smu_pkg::MASK_OUT_W-1:0]     ended;
    logic [smu_pkg::ID_BITS_DEF-1:0]    last_id;
    logic                               have_last;
    logic                               finished;

    merge_res_t expected_q[$];

    task automatic report(input string msg);
        if (fail_count < 40)
            $display("%0t merge check: %s", $time, msg);
        fail_count++;
    endtask

    // Lists taking part: a count of 0 acts as 1, above the maximum as the maximum
    function automatic int lists_in_use();
        if (cfg_lists == 0)
            return 1;
        if (cfg_lists > NL)
            return NL;
        return int'(cfg_lists);
    endfunction

    function automatic logic [smu_pkg::MASK_OUT_W-1:0] lists_mask();
        return smu_pkg::MASK_OUT_W'((9'd1 << lists_in_use()) - 9'd1);
    endfunction

    // One input transaction applied to the mirrored heads
    task automatic predict_merge(input logic f,
                                 input logic [smu_pkg::LIST_INDEX_W-1:0] idx,
                                 input logic [smu_pkg::ID_BITS_DEF-1:0] rid,
                                 input logic [smu_pkg::SCORE_BITS_DEF-1:0] sc,
                                 input logic lend, output merge_res_t res);
        logic [smu_pkg::MASK_OUT_W-1:0] all;
        logic [smu_pkg::MASK_OUT_W-1:0] bitm;
        logic [smu_pkg::MASK_OUT_W-1:0] live;
        logic                           found;
        all = lists_mask();
        res = '0;
        res.kind = smu_pkg::KIND_WAIT;
        if (f == smu_pkg::FUNC_START)
        begin
            hd_valid  = '0;
            ended     = '0;
            last_id   = '0;
            have_last = 1'b0;
            finished  = 1'b0;
            res.rmask = all;
        end
        else if (finished)
        begin
            res.kind = smu_pkg::KIND_FINISHED;
        end
        else
        begin
            if (int'(idx) < lists_in_use())
            begin
                bitm = smu_pkg::MASK_OUT_W'(1) << idx;
                if (lend)
                begin
                    ended    |= bitm;
                    hd_valid &= ~bitm;
                end
                else if ((ended & bitm) == '0)
                begin
                    // repeat IDs are dropped and the list keeps needing a refill
                    if (have_last && rid <= last_id)
                        hd_valid &= ~bitm;
                    else
                    begin
                        hd_id[idx] = rid;
                        hd_sc[idx] = sc;
                        hd_valid  |= bitm;
                    end
                end
            end
            live = all & ~ended;
            if (live == '0)
            begin
                finished = 1'b1;
                res.kind = smu_pkg::KIND_FINISHED;
            end
            else if ((hd_valid & live) == live)
            begin
                // smallest head wins; ties merge their masks and keep the top score
                found = 1'b0;
                for (int i = 0; i < NL; i++)
                begin
                    if (live[i])
                    begin
                        if (!found || hd_id[i] < res.id)
                        begin
                            found     = 1'b1;
                            res.id    = hd_id[i];
                            res.score = hd_sc[i];
                            res.mmask = smu_pkg::MASK_OUT_W'(1) << i;
                        end
                        else if (hd_id[i] == res.id)
                        begin
                            if (hd_sc[i] > res.score)
                                res.score = hd_sc[i];
                            res.mmask[i] = 1'b1;
                        end
                    end
                end
                hd_valid  &= ~res.mmask;
                last_id    = res.id;
                have_last  = 1'b1;
                res.kind   = smu_pkg::KIND_RECORD;
                res.rmask  = live & ~hd_valid;
            end
            else
            begin
                res.rmask = live & ~hd_valid;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        merge_res_t got;
        merge_res_t want;
        if (!rst_n)
        begin
            cfg_lists  = smu_pkg::ACTIVE_LISTS_RST;
            hd_valid   = '0;
            ended      = '0;
            last_id    = '0;
            have_last  = 1'b0;
            finished   = 1'b0;
            expected_q.delete();
            fail_count = 0;
            pending    = 0;
            taken      = 0;
            records    = 0;
            finishes   = 0;
            cfg_writes = 0;
        end
        else
        begin
            // register writes
            if (psel && penable && pwrite && pready && paddr == LISTS_ADDR)
            begin
                cfg_lists = pwdata[smu_pkg::CFG_LISTS_W-1:0];
                cfg_writes++;
            end

            // output transaction against the oldest prediction
            if (out_ch.valid && out_ch.ready)
            begin
                got = '{out_ch.kind, out_ch.out_id, out_ch.best_score,
                        out_ch.match_mask, out_ch.refill_mask};
                if (expected_q.size() == 0)
                    report($sformatf("result with nothing pending, kind %0d id %0h",
                                     got.kind, got.id));
                else
                begin
                    want = expected_q.pop_front();
                    if (got.kind != want.kind)
                        report($sformatf("kind %0d, expected %0d", got.kind, want.kind));
                    if (got.id != want.id)
                        report($sformatf("out_id %0h, expected %0h", got.id, want.id));
                    if (got.score != want.score)
                        report($sformatf("best_score %0h, expected %0h",
                                         got.score, want.score));
                    if (got.mmask != want.mmask)
                        report($sformatf("match_mask %02h, expected %02h",
                                         got.mmask, want.mmask));
                    if (got.rmask != want.rmask)
                        report($sformatf("refill_mask %02h, expected %02h",
                                         got.rmask, want.rmask));
                    if (want.kind == smu_pkg::KIND_RECORD)
                        records++;
                    if (want.kind == smu_pkg::KIND_FINISHED)
                        finishes++;
                end
            end

            // input transaction: predict and queue at the tail
            if (in_ch.valid && in_ch.ready)
            begin
                predict_merge(in_ch.func, in_ch.list_index, in_ch.record_id,
                              in_ch.score, in_ch.list_end, want);
                expected_q.insert(expected_q.size(), want);
                taken++;
            end

            pending = expected_q.size();
        end
        refill_need = lists_mask() & ~ended & ~hd_valid;
        union_done  = finished;
    end

endmodule

[tb/sorted_id_list_union_merge_tb.sv]
// ============================================================================
// sorted_id_list_union_merge_tb
// Drives the union merge with a directed opening and then random unions of
// sorted lists with noise, under bursty input and a stalling output, while
// the checker beside the block predicts and compares every result.
// ============================================================================
module sorted_id_list_union_merge_tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int ITEM_TARGET = 380;
    localparam int NL          = smu_pkg::MAX_LISTS_DEF;
    localparam logic [smu_pkg::APB_ADDR_W-1:0] LISTS_ADDR =
        {smu_pkg::REG_ACTIVE_LISTS, 2'b00};

    logic                           clk;
    logic                           rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [smu_pkg::APB_ADDR_W-1:0] paddr;
    logic [smu_pkg::APB_DATA_W-1:0] pwdata;
    logic [smu_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    int                             fail_count;
    int                             pending;
    int                             taken;
    int                             records;
    int                             finishes;
    int                             cfg_writes;
    logic [smu_pkg::MASK_OUT_W-1:0] refill_need;
    logic                           union_done;

    int                             cycles;
    int                             items_sent;
    int                             burst_left;
    bit                             quiet;

    // per-list generator state for well-formed unions
    logic [31:0]           cursor [NL];
    logic [31:0]           prev_id [NL];
    bit                    fed [NL];
    int                    left [NL];

    smu_in_if  in_ch ();
    smu_out_if out_ch ();

    sorted_id_list_union_merge u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    sorted_id_list_union_merge_chk u_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .fail_count  (fail_count),
        .pending     (pending),
        .taken       (taken),
        .records     (records),
        .finishes    (finishes),
        .cfg_writes  (cfg_writes),
        .refill_need (refill_need),
        .union_done  (union_done)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // watchdog
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
        $display("[FAIL] regression broken");
        $finish;
    end

    // output side: stalls on its own pattern
    initial
    begin
        int mode;
        int span;
        int stall_left;
        out_ch.ready = 1'b0;
        stall_left   = 0;
        forever
        begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(16, 64);
            repeat (span)
            begin
                @(negedge clk);
                if (stall_left > 0)
                begin
                    stall_left--;
                    out_ch.ready = 1'b0;
                end
                else
                begin
                    case (mode)
                        0:       out_ch.ready = 1'b1;
                        1:       out_ch.ready = 1'($urandom_range(0, 1));
                        default:
                        begin
                            out_ch.ready = 1'b1;
                            if ($urandom_range(0, 11) == 0)
                                stall_left = $urandom_range(3, 15);
                        end
                    endcase
                end
            end
        end
    end

    // one input transaction; valid stays high through a burst
    task automatic send(input logic f, input logic [smu_pkg::LIST_INDEX_W-1:0] idx,
                        input logic [31:0] rid, input logic [15:0] sc, input logic lend);
        int gap;
        in_ch.valid      = 1'b1;
        in_ch.func       = f;
        in_ch.list_index = idx;
        in_ch.record_id  = rid;
        in_ch.score      = sc;
        in_ch.list_end   = lend;
        do @(posedge clk); while (!in_ch.ready);
        items_sent++;
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            in_ch.valid = 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(negedge clk);
            burst_left = quiet ? 200 : $urandom_range(1, 10);
        end
    endtask

    // hold the input until every predicted result has drained
    task automatic wait_idle();
        in_ch.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    task automatic write_lists(input logic [smu_pkg::CFG_LISTS_W-1:0] val);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = LISTS_ADDR;
        pwdata  = ($urandom & 32'hFFFF_FFF0) | smu_pkg::APB_DATA_W'(val);
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // union of sorted lists steered by the lists that need a refill,
    // with some noise: stray deliveries, repeat IDs and early end marks
    task automatic run_union(input int len_max, input bit wide, input bit shift_cfg);
        logic [31:0]                    base;
        logic [smu_pkg::MASK_OUT_W-1:0] need;
        int                             pick;
        int                             r;
        int                             guard;
        base = wide ? $urandom : 32'($urandom_range(0, 40));
        if ($urandom_range(0, 5) == 0)
            base = 32'hFFFF_FFE0;
        for (int i = 0; i < NL; i++)
        begin
            cursor[i] = base + 32'($urandom_range(0, 6));
            left[i]   = $urandom_range(0, len_max);
            fed[i]    = 1'b0;
        end
        quiet      = ($urandom_range(0, 3) == 0);
        burst_left = quiet ? 200 : $urandom_range(1, 10);
        send(smu_pkg::FUNC_START, 3'($urandom), $urandom, 16'($urandom), 1'($urandom));
        guard = 0;
        while (!union_done && guard < 400)
        begin
            guard++;
            // list count changed in the middle of a union
            if (shift_cfg && guard == 6)
            begin
                wait_idle();
                write_lists(smu_pkg::CFG_LISTS_W'($urandom_range(0, 15)));
            end
            need = refill_need;
            r    = $urandom_range(0, 99);
            if (need == '0 || r < 6)
                send(smu_pkg::FUNC_DELIVER, 3'($urandom), $urandom, 16'($urandom),
                     $urandom_range(0, 3) == 0);
            else
            begin
                do pick = $urandom_range(0, NL - 1); while (!need[pick]);
                if (r < 10 && fed[pick])
                    send(smu_pkg::FUNC_DELIVER, 3'(pick), prev_id[pick], 16'($urandom),
                         1'b0);
                else if (left[pick] == 0)
                    send(smu_pkg::FUNC_DELIVER, 3'(pick), $urandom, 16'($urandom), 1'b1);
                else
                begin
                    send(smu_pkg::FUNC_DELIVER, 3'(pick), cursor[pick], 16'($urandom),
                         1'b0);
                    prev_id[pick] = cursor[pick];
                    fed[pick]     = 1'b1;
                    left[pick]--;
                    if (cursor[pick] > 32'hFFFF_FFF0)
                        left[pick] = 0;
                    else
                        cursor[pick] += 32'($urandom_range(1, 4));
                end
            end
        end
        // deliveries after the union has finished
        repeat ($urandom_range(0, 2))
            send(smu_pkg::FUNC_DELIVER, 3'($urandom), $urandom, 16'($urandom),
                 1'($urandom));
    endtask

    // stimulus and verdict
    initial
    begin
        logic [smu_pkg::CFG_LISTS_W-1:0] fixed_cfg [5];
        int                              phase;
        fixed_cfg        = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd9};
        rst_n            = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        in_ch.valid      = 1'b0;
        in_ch.func       = smu_pkg::FUNC_START;
        in_ch.list_index = '0;
        in_ch.record_id  = '0;
        in_ch.score      = '0;
        in_ch.list_end   = 1'b0;
        items_sent       = 0;
        burst_left       = 1;
        quiet            = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed opening at the reset count of two lists
        send(smu_pkg::FUNC_START,   3'd0, 32'h0,         16'h0,    1'b0);
        send(smu_pkg::FUNC_DELIVER, 3'd0, 32'h0,         16'hFFFF, 1'b0);
        send(smu_pkg::FUNC_DELIVER, 3'd1, 32'h0,         16'h0001, 1'b0);  // tie at zero
        send(smu_pkg::FUNC_DELIVER, 3'd0, 32'h0,         16'h1234, 1'b0);  // repeat dropped
        send(smu_pkg::FUNC_DELIVER, 3'd5, 32'h55,        16'h0,    1'b0);  // index too high
        send(smu_pkg::FUNC_DELIVER, 3'd0, 32'hFFFF_FFFF, 16'h8000, 1'b0);
        send(smu_pkg::FUNC_DELIVER, 3'd0, 32'd10,        16'h0005, 1'b0);  // head replaced
        send(smu_pkg::FUNC_DELIVER, 3'd1, 32'hFFFF_FFFF, 16'h0,    1'b0);
        send(smu_pkg::FUNC_DELIVER, 3'd0, 32'h0,         16'h0,    1'b1);  // list 0 ends
        send(smu_pkg::FUNC_DELIVER, 3'd0, 32'd20,        16'h0007, 1'b0);  // ended list
        send(smu_pkg::FUNC_DELIVER, 3'd1, 32'h0,         16'h0,    1'b1);  // union finishes
        send(smu_pkg::FUNC_DELIVER, 3'd1, 32'd7,         16'h0003, 1'b0);
        send(smu_pkg::FUNC_DELIVER, 3'd7, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
        send(smu_pkg::FUNC_START,   3'd7, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
        send(smu_pkg::FUNC_DELIVER, 3'd1, 32'd3,         16'h00FF, 1'b0);
        send(smu_pkg::FUNC_DELIVER, 3'd0, 32'd3,         16'hFF00, 1'b0);  // tie, top score
        send(smu_pkg::FUNC_DELIVER, 3'd1, 32'd2,         16'h0,    1'b0);  // below last
        send(smu_pkg::FUNC_DELIVER, 3'd1, 32'd4,         16'h0,    1'b0);

        // random phases, each at its own list count
        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            wait_idle();
            write_lists(phase < 5 ? fixed_cfg[phase]
                                  : smu_pkg::CFG_LISTS_W'($urandom_range(0, 15)));
            repeat (3)
                run_union(($urandom_range(0, 7) == 0) ? 10 : 4, 1'($urandom_range(0, 1)),
                          $urandom_range(0, 4) == 0);
            phase++;
        end

        // drain
        in_ch.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (16) @(negedge clk);

        $display("run: %0d input transactions over %0d register writes and %0d phases",
                 taken, cfg_writes, phase);
        $display("run: %0d merged records, %0d finished answers", records, finishes);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[sorted_id_list_union_merge.f]
src/smu_pkg.sv
src/smu_in_if.sv
src/smu_out_if.sv
src/smu_cfg.sv
src/smu_ctrl.sv
src/smu_dp.sv
src/sorted_id_list_union_merge.sv
tb/sorted_id_list_union_merge_chk.sv
tb/sorted_id_list_union_merge_tb.sv
